[sv/rfc_equivalence_class_table_assert.svh]
// Assertion macros for the equivalence class table.
`ifndef RFC_EQUIVALENCE_CLASS_TABLE_ASSERT_SVH
`define RFC_EQUIVALENCE_CLASS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define RFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("equivalence class table check failed");
`define RFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("equivalence class table check failed");
`else
`define RFC_ASSERT_NOW(label, ante, cons)
`define RFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/rfc_pkg.sv]
// Shared constants and controller/datapath interface types.
package rfc_pkg;
    localparam int BMP_W       = 64;
    localparam int MAX_CLASSES = 256;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

    localparam logic OP_CLEAR    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic rd_en;
        logic emit_hit;
        logic append;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic issue_more;
        logic hit;
        logic cmp_last;
    } t_sts;
endpackage

[sv/rfc_ctrl.sv]
// Controller state machine for the equivalence class search.
`include "rfc_equivalence_class_table_assert.svh"
module rfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_opcode,
    input  rfc_pkg::t_sts i_sts,
    output rfc_pkg::t_cmd o_cmd,
    output logic          busy
);
    import rfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_APPEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = i_sts.cnt_zero ? S_APPEND : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = i_sts.issue_more;
                if (i_sts.hit) begin
                    o_cmd.emit_hit = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.cmp_last) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    `RFC_ASSERT_NEXT(a_hit_ends, r_state == S_SCAN && i_sts.hit, r_state == S_IDLE)
    `RFC_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({o_cmd.clear, o_cmd.load, o_cmd.emit_hit, o_cmd.append}))
endmodule

[sv/rfc_dpath.sv]
// Datapath: class memory, search pointers, count and result registers.
`include "rfc_equivalence_class_table_assert.svh"
module rfc_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rfc_pkg::t_cmd i_cmd,
    input  logic [63:0]   i_rule_bitmap,
    output rfc_pkg::t_sts o_sts,
    output logic          o_valid,
    output logic [7:0]    o_class_id,
    output logic          o_is_new,
    output logic          o_overflow,
    output logic [8:0]    o_class_count
);
    import rfc_pkg::*;

    logic [BMP_W-1:0] r_mem [MAX_CLASSES];
    logic [BMP_W-1:0] r_rd_data;
    logic [BMP_W-1:0] r_bitmap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_valid;
    logic             r_valid;
    logic [7:0]       r_class_id;
    logic             r_is_new;
    logic             r_ovf;
    logic [8:0]       r_count_out;
    logic             full;
    logic             hit;
    logic             do_write;

    assign full     = (r_count == CNT_W'(MAX_CLASSES));
    assign hit      = r_cmp_valid && (r_rd_data == r_bitmap);
    assign do_write = i_cmd.append && !full;

    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.full       = full;
    assign o_sts.issue_more = (r_idx < r_count);
    assign o_sts.hit        = hit;
    assign o_sts.cmp_last   = r_cmp_valid && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_count[IDX_W-1:0]] <= r_bitmap;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_bitmap <= i_rule_bitmap[BMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.rd_en && !i_cmd.load;
            r_valid     <= i_cmd.clear || i_cmd.emit_hit || i_cmd.append;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (do_write) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_class_id  <= '0;
            r_is_new    <= 1'b0;
            r_ovf       <= 1'b0;
            r_count_out <= '0;
        end else if (i_cmd.emit_hit) begin
            r_class_id  <= 8'(r_cmp_idx);
            r_is_new    <= 1'b0;
            r_ovf       <= 1'b0;
            r_count_out <= 9'(r_count);
        end else if (i_cmd.append) begin
            r_class_id  <= full ? 8'd0 : 8'(r_count);
            r_is_new    <= !full;
            r_ovf       <= full;
            r_count_out <= full ? 9'(r_count) : 9'(r_count + CNT_W'(1));
        end
    end

    assign o_valid       = r_valid;
    assign o_class_id    = r_class_id;
    assign o_is_new      = r_is_new;
    assign o_overflow    = r_ovf;
    assign o_class_count = r_count_out;

    `RFC_ASSERT_NOW(a_cnt_max, 1'b1, r_count <= CNT_W'(MAX_CLASSES))
    `RFC_ASSERT_NOW(a_new_xor_ovf, r_valid, !(r_is_new && r_ovf))
    `RFC_ASSERT_NEXT(a_clear_cnt, i_cmd.clear, r_count == '0)
    `RFC_ASSERT_NEXT(a_append_cnt, do_write, r_count == $past(r_count) + CNT_W'(1))
endmodule

[sv/rfc_equivalence_class_table.sv]
// Top level of the equivalence class table: controller plus datapath.
// An item is taken when start is high and busy is low. A clear never leaves idle
// and its result appears the cycle after; busy stays low. A classify item with
// N classes stored walks the class memory one entry per cycle through its
// single registered read port; a match ends the walk, and a miss (new class or
// overflow) appends after entry N-1 is compared, or straight after the load when
// the table is empty. Each result is shown for one cycle with o_valid high and must
// be taken then; the receiver cannot stall the block. The memory needs no
// clearing pass after reset, since only entries below the class count are read.
module rfc_equivalence_class_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [63:0] i_rule_bitmap,
    output logic        o_valid,
    output logic [7:0]  o_class_id,
    output logic        o_is_new,
    output logic        o_overflow,
    output logic [8:0]  o_class_count
);
    import rfc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    rfc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rule_bitmap (i_rule_bitmap),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_class_id    (o_class_id),
        .o_is_new      (o_is_new),
        .o_overflow    (o_overflow),
        .o_class_count (o_class_count)
    );
endmodule

[test/rfc_equivalence_class_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the equivalence class table: directed rows, then random words.
module rfc_equivalence_class_table_tb;
    import rfc_pkg::*;

    typedef struct packed {
        logic [7:0] class_id;
        logic       is_new;
        logic       overflow;
        logic [8:0] class_count;
    } t_class_result;

    typedef struct packed {
        logic          opcode;
        logic [63:0]   bitmap;
        logic          typed;
        t_class_result result;
    } t_stim_row;

    localparam int DIR_ROWS = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_opcode = OP_CLEAR;
    logic [63:0] i_rule_bitmap = '0;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_class_id;
    logic        o_is_new;
    logic        o_overflow;
    logic [8:0]  o_class_count;

    logic [BMP_W-1:0] class_mem [MAX_CLASSES];
    int unsigned      class_total = 0;
    t_class_result    pending_results[$];
    t_stim_row        directed_rows [DIR_ROWS];

    bit idle_on = 1'b1;
    int words_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int clear_count = 0;
    int hit_count = 0;
    int append_count = 0;
    int overflow_count = 0;

    rfc_equivalence_class_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_rule_bitmap (i_rule_bitmap),
        .o_valid       (o_valid),
        .o_class_id    (o_class_id),
        .o_is_new      (o_is_new),
        .o_overflow    (o_overflow),
        .o_class_count (o_class_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_class_result classify_word(logic op, logic [63:0] bmp);
        t_class_result    r;
        logic [BMP_W-1:0] key;
        r = '0;
        key = bmp[BMP_W-1:0];
        if (op == OP_CLEAR) begin
            class_total = 0;
            clear_count++;
            return r;
        end
        for (int k = 0; k < class_total; k++) begin
            if (class_mem[k] == key) begin
                r.class_id = 8'(k);
                r.class_count = 9'(class_total);
                hit_count++;
                return r;
            end
        end
        if (class_total >= MAX_CLASSES) begin
            r.overflow = 1'b1;
            r.class_count = 9'(class_total);
            overflow_count++;
            return r;
        end
        class_mem[class_total] = key;
        r.class_id = 8'(class_total);
        r.is_new = 1'b1;
        class_total++;
        r.class_count = 9'(class_total);
        append_count++;
        return r;
    endfunction

    function automatic t_stim_row row(logic op, logic [63:0] bmp, logic typed,
                                      logic [7:0] id, logic fresh, logic ovf, logic [8:0] cnt);
        t_stim_row s;
        s.opcode = op;
        s.bitmap = bmp;
        s.typed = typed;
        s.result = '{id, fresh, ovf, cnt};
        return s;
    endfunction

    function automatic logic [63:0] rand_bitmap();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'd1 << $urandom_range(0, 63);
            1: v = '0;
            2: v = '1;
            3: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            4: v = v | {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 11);
        @(negedge i_clk);
        start <= 1'b0;
        i_opcode <= 1'($urandom);
        i_rule_bitmap <= {$urandom, $urandom};
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_word(logic op, logic [63:0] bmp, logic typed, t_class_result given);
        t_class_result pred;
        @(negedge i_clk);
        start <= 1'b1;
        i_opcode <= op;
        i_rule_bitmap <= bmp;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = classify_word(op, bmp);
        pending_results.push_back(typed ? given : pred);
        words_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
            idle_burst();
    endtask

    task automatic send_classify(logic [63:0] bmp);
        send_word(OP_CLASSIFY, bmp, 1'b0, '0);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_mix(int n, int clear_pct);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < clear_pct)
                send_word(OP_CLEAR, {$urandom, $urandom}, 1'b0, '0);
            else if (class_total > 0 && r < 55)
                send_classify(class_mem[$urandom_range(0, class_total - 1)]);
            else
                send_classify(rand_bitmap());
        end
    endtask

    task automatic fill_table();
        send_word(OP_CLEAR, {$urandom, $urandom}, 1'b0, '0);
        while (class_total < MAX_CLASSES) begin
            if (class_total > 0 && $urandom_range(0, 7) == 0)
                send_classify(class_mem[$urandom_range(0, class_total - 1)]);
            else
                send_classify({$urandom, $urandom});
        end
        for (int i = 0; i < 20; i++) begin
            case ($urandom_range(0, 3))
                0: send_classify(class_mem[MAX_CLASSES - 1]);
                1: send_classify(class_mem[0]);
                2: send_classify(class_mem[$urandom_range(0, MAX_CLASSES - 1)]);
                default: send_classify({$urandom, $urandom});
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_class_result got;
        t_class_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_class_id, o_is_new, o_overflow, o_class_count};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: id=%0d new=%b ovf=%b count=%0d",
                             got.class_id, got.is_new, got.overflow, got.class_count);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected id=%0d new=%b ovf=%b count=%0d",
                                 want.class_id, want.is_new, want.overflow, want.class_count);
                        $display("          got      id=%0d new=%b ovf=%b count=%0d",
                                 got.class_id, got.is_new, got.overflow, got.class_count);
                    end
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        directed_rows[0]  = row(OP_CLASSIFY, 64'h0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1);
        directed_rows[1]  = row(OP_CLASSIFY, '1, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2);
        directed_rows[2]  = row(OP_CLASSIFY, 64'h0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd2);
        directed_rows[3]  = row(OP_CLASSIFY, '1, 1'b1, 8'd1, 1'b0, 1'b0, 9'd2);
        directed_rows[4]  = row(OP_CLASSIFY, 64'h8000_0000_0000_0000, 1'b1, 8'd2, 1'b1, 1'b0, 9'd3);
        directed_rows[5]  = row(OP_CLASSIFY, 64'h1, 1'b1, 8'd3, 1'b1, 1'b0, 9'd4);
        directed_rows[6]  = row(OP_CLASSIFY, 64'h8000_0000_0000_0000, 1'b1, 8'd2, 1'b0, 1'b0, 9'd4);
        directed_rows[7]  = row(OP_CLEAR, '1, 1'b1, 8'd0, 1'b0, 1'b0, 9'd0);
        directed_rows[8]  = row(OP_CLEAR, 64'h0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd0);
        directed_rows[9]  = row(OP_CLASSIFY, '1, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1);
        directed_rows[10] = row(OP_CLASSIFY, 64'h5555_5555_5555_5555, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[11] = row(OP_CLASSIFY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[12] = row(OP_CLASSIFY, 64'h5555_5555_5555_5555, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[13] = row(OP_CLASSIFY, 64'h0000_0001_0000_0000, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[14] = row(OP_CLASSIFY, 64'hFFFF_FFFF_0000_0000, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[15] = row(OP_CLASSIFY, 64'h0000_0000_FFFF_FFFF, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[16] = row(OP_CLASSIFY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[17] = row(OP_CLASSIFY, 64'h0, 1'b0, '0, 1'b0, 1'b0, '0);
        directed_rows[18] = row(OP_CLEAR, 64'h0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd0);
        directed_rows[19] = row(OP_CLASSIFY, 64'h0123_4567_89AB_CDEF, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(directed_rows[i].opcode, directed_rows[i].bitmap,
                      directed_rows[i].typed, directed_rows[i].result);

        run_mix(150, 4);
        @(negedge i_clk);
        start <= 1'b0;
        drain();
        fill_table();
        run_mix(100, 3);
        fill_table();
        @(negedge i_clk);
        start <= 1'b0;
        drain();
        idle_on = 1'b0;
        run_mix(150, 3);
        @(negedge i_clk);
        start <= 1'b0;

        drain();
        repeat (300) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count += pending_results.size();

        $display("covered %0d words, %0d results: %0d clears, %0d hits, %0d appends",
                 words_sent, results_seen, clear_count, hit_count, append_count);
        $display("two full-table passes with %0d overflows; %0d mismatches",
                 overflow_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/rfc_pkg.sv
sv/rfc_ctrl.sv
sv/rfc_dpath.sv
sv/rfc_equivalence_class_table.sv
test/rfc_equivalence_class_table_tb.sv
